>>> sv/nars_pkg.sv
// shared types and constants of the newline aligned range splitter
package nars_pkg;

  localparam int NUM_BITS       = 6;
  localparam int CFG_INDEX_BITS = 2;
  localparam int MAX_WORKERS    = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FILE_SIZE    = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WORKER_COUNT = CFG_INDEX_BITS'(1);

  // what one accepted byte asks of the result side
  typedef struct packed {
    logic                first;      // boundary 0 goes out
    logic                hit;        // newline closes a range
    logic [NUM_BITS-1:0] hit_num;    // number of that boundary
    logic                eof;        // pending boundaries go out as the file size
    logic [NUM_BITS-1:0] eof_start;  // first pending boundary
    logic [NUM_BITS-1:0] workers;    // effective worker count
  } nars_ctrl_t;

endpackage

>>> sv/nars_divider.sv
// restoring divider for file size over worker count, one quotient bit a cycle
module nars_divider #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [OFFSET_BITS-1:0]        dividend,
  input  logic [nars_pkg::NUM_BITS-1:0] divisor,
  output logic                          busy,
  output logic [OFFSET_BITS-1:0]        quotient,
  output logic [nars_pkg::NUM_BITS-1:0] remainder
);
  import nars_pkg::*;

  localparam int CNT_BITS = $clog2(OFFSET_BITS);

  logic [CNT_BITS-1:0] count;
  logic [NUM_BITS:0]   trial;
  logic                fits;

  assign trial = {remainder, dividend[OFFSET_BITS-1-count]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      quotient  <= OFFSET_BITS'(1);
      remainder <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= '0;
      quotient  <= '0;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[OFFSET_BITS-2:0], fits};
      remainder <= fits ? NUM_BITS'(trial - {1'b0, divisor}) : NUM_BITS'(trial);
      if (count == CNT_BITS'(OFFSET_BITS - 1)) begin
        busy <= 1'b0;
      end
      count <= count + 1'b1;
    end
  end

endmodule

>>> sv/nars_front.sv
// front side: takes bytes, tracks targets and newlines, queues result requests
module nars_front #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_file,
  input  logic [nars_pkg::NUM_BITS-1:0] workers,
  input  logic [OFFSET_BITS-1:0]        quotient,
  input  logic [nars_pkg::NUM_BITS-1:0] remainder,
  input  logic                          div_busy,
  input  logic                          queue_full,
  output logic                          push,
  output nars_pkg::nars_ctrl_t          push_ctrl,
  output logic [OFFSET_BITS-1:0]        push_ofs
);
  import nars_pkg::*;

  logic [OFFSET_BITS-1:0] byte_position;
  logic [NUM_BITS-1:0]    next_boundary;
  logic [OFFSET_BITS:0]   search_start;
  logic [OFFSET_BITS-1:0] even_target;
  logic [NUM_BITS-1:0]    target_remainder;

  logic                   accept;
  logic                   first;
  logic [NUM_BITS-1:0]    nb0;
  logic [NUM_BITS-1:0]    nb1;
  logic [OFFSET_BITS-1:0] even0;
  logic [OFFSET_BITS-1:0] even1;
  logic [NUM_BITS-1:0]    rem0;
  logic [NUM_BITS-1:0]    rem1;
  logic [OFFSET_BITS:0]   ss0;
  logic [OFFSET_BITS:0]   ss1;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS:0]   after;
  logic [NUM_BITS:0]      sum;
  logic                   carry;
  logic                   hit;
  logic                   step;
  logic                   eof_part;
  logic                   norm;

  // remainder left at or above a smaller worker count is folded back first
  assign norm     = !div_busy && (target_remainder >= workers);
  assign in_ready = !div_busy && !norm && !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first = (next_boundary == '0);
    nb0   = first ? NUM_BITS'(1) : next_boundary;
    even0 = first ? quotient : even_target;
    rem0  = first ? remainder : target_remainder;
    ss0   = first ? {1'b0, quotient} : search_start;
    pos   = first ? '0 : byte_position;
    after = {1'b0, pos} + 1'b1;

    hit = (data_byte == NEWLINE_BYTE) && (nb0 < workers) && (ss0 <= {1'b0, pos});
    nb1 = hit ? nb0 + 1'b1 : nb0;
    step = hit && (nb1 < workers);

    sum   = {1'b0, rem0} + {1'b0, remainder};
    carry = sum >= {1'b0, workers};
    rem1  = carry ? NUM_BITS'(sum - {1'b0, workers}) : NUM_BITS'(sum);
    even1 = even0 + quotient + OFFSET_BITS'(carry);
    ss1   = ({1'b0, even1} > after) ? {1'b0, even1} : after;

    eof_part = end_of_file && (nb1 <= workers);
  end

  assign push = accept && (first || hit || eof_part);

  always_comb begin
    push_ctrl.first     = first;
    push_ctrl.hit       = hit;
    push_ctrl.hit_num   = nb0;
    push_ctrl.eof       = eof_part;
    push_ctrl.eof_start = nb1;
    push_ctrl.workers   = workers;
    push_ofs            = after[OFFSET_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      next_boundary    <= '0;
      search_start     <= '0;
      even_target      <= '0;
      target_remainder <= '0;
    end else if (accept) begin
      if (end_of_file) begin
        byte_position    <= '0;
        next_boundary    <= '0;
        search_start     <= '0;
        even_target      <= '0;
        target_remainder <= '0;
      end else begin
        byte_position    <= after[OFFSET_BITS-1:0];
        next_boundary    <= nb1;
        even_target      <= step ? even1 : even0;
        target_remainder <= step ? rem1 : rem0;
        search_start     <= step ? ss1 : ss0;
      end
    end else if (norm) begin
      target_remainder <= target_remainder - workers;
      even_target      <= even_target + 1'b1;
    end
  end

endmodule

>>> sv/nars_fifo.sv
// short queue of result requests between front and back
module nars_fifo #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  nars_pkg::nars_ctrl_t   push_ctrl,
  input  logic [OFFSET_BITS-1:0] push_ofs,
  input  logic                   pop,
  output logic                   full,
  output logic                   head_valid,
  output nars_pkg::nars_ctrl_t   head_ctrl,
  output logic [OFFSET_BITS-1:0] head_ofs
);
  import nars_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  nars_ctrl_t             ctrl_mem [QUEUE_DEPTH];
  logic [OFFSET_BITS-1:0] ofs_mem  [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [PTR_BITS-1:0]    rd_ptr;
  logic [PTR_BITS:0]      count;

  assign full       = (count == (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_ctrl  = ctrl_mem[rd_ptr];
  assign head_ofs   = ofs_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr] <= push_ctrl;
      ofs_mem[wr_ptr]  <= push_ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/nars_back.sv
// back side: expands each queued request into boundaries, one a cycle while out_ready does not stall it
module nars_back #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  nars_pkg::nars_ctrl_t          head_ctrl,
  input  logic [OFFSET_BITS-1:0]        head_ofs,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OFFSET_BITS-1:0]        out_ofs,
  output logic [nars_pkg::NUM_BITS-1:0] out_num,
  output logic                          out_last
);
  import nars_pkg::*;

  logic                   first_done;
  logic                   hit_done;
  logic                   eof_busy;
  logic [NUM_BITS-1:0]    k;

  logic                   load;
  logic                   advance;
  logic                   take_first;
  logic                   take_hit;
  logic [NUM_BITS-1:0]    kc;
  logic                   last_piece;
  logic [OFFSET_BITS-1:0] res_ofs;
  logic [NUM_BITS-1:0]    res_num;

  assign load    = !out_valid || out_ready;
  assign advance = head_valid && load;

  always_comb begin
    take_first = head_ctrl.first && !first_done;
    take_hit   = !take_first && head_ctrl.hit && !hit_done;
    kc         = eof_busy ? k : head_ctrl.eof_start;
    if (take_first) begin
      last_piece = !(head_ctrl.hit || head_ctrl.eof);
      res_ofs    = '0;
      res_num    = '0;
    end else if (take_hit) begin
      last_piece = !head_ctrl.eof;
      res_ofs    = head_ofs;
      res_num    = head_ctrl.hit_num;
    end else begin
      last_piece = (kc == head_ctrl.workers);
      res_ofs    = head_ofs;
      res_num    = kc;
    end
  end

  assign pop = advance && last_piece;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ofs  <= res_ofs;
      out_num  <= res_num;
      out_last <= (res_num == head_ctrl.workers);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      first_done <= 1'b0;
      hit_done   <= 1'b0;
      eof_busy   <= 1'b0;
      k          <= '0;
    end else begin
      if (load) begin
        out_valid <= head_valid;
      end
      if (advance) begin
        if (last_piece) begin
          first_done <= 1'b0;
          hit_done   <= 1'b0;
          eof_busy   <= 1'b0;
        end else if (take_first) begin
          first_done <= 1'b1;
        end else if (take_hit) begin
          hit_done <= 1'b1;
        end else begin
          eof_busy <= 1'b1;
          k        <= kc + 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/newline_aligned_range_splitter_core.sv
// top level of the newline aligned range splitter
//
// channel  | dir | handshake         | contents
// ---------+-----+-------------------+--------------------------------------------
// s_*      | in  | s_tvalid/s_tready | one file byte, s_tlast on the last byte
// m_*      | out | m_tvalid/m_tready | one boundary offset and number, m_tlast on
//          |     |                   | the boundary equal to the worker count
// cfg_*    | in  | cfg_we            | file size (index 0), worker count (index 1)
//
// one byte a cycle while s_tready is high; results leave one a cycle while m_tready is
// high, so a byte that opens a file and hits a newline, or the end-of-file byte, keeps
// the back busy while the four-entry queue lets bytes keep coming
// every config write restarts the quotient/remainder divider: s_tready stays low
// while it runs, and then while the remainder is folded back when the worker count
// drops mid-file
// reset is synchronous; the queue and output register come up empty
// the output register takes a new transaction whenever it is empty or drained, so a
// stalled m_tready backs up into the queue and, once that is full, into s_tready
module newline_aligned_range_splitter_core #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  // data_byte
  input  logic [7:0]                          s_tdata,
  input  logic                                s_tlast,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // boundary_offset, boundary_number, zero pad
  output logic [((OFFSET_BITS + nars_pkg::NUM_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [nars_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [OFFSET_BITS-1:0]              cfg_data
);
  import nars_pkg::*;

  localparam int TDATA_BITS = ((OFFSET_BITS + NUM_BITS + 7) / 8) * 8;

  logic [OFFSET_BITS-1:0] file_size;
  logic [NUM_BITS-1:0]    worker_count;
  logic [NUM_BITS-1:0]    workers;

  logic                   div_busy;
  logic [OFFSET_BITS-1:0] quotient;
  logic [NUM_BITS-1:0]    remainder;

  logic                   push;
  nars_ctrl_t             push_ctrl;
  logic [OFFSET_BITS-1:0] push_ofs;
  logic                   pop;
  logic                   queue_full;
  logic                   head_valid;
  nars_ctrl_t             head_ctrl;
  logic [OFFSET_BITS-1:0] head_ofs;

  logic [OFFSET_BITS-1:0] out_ofs;
  logic [NUM_BITS-1:0]    out_num;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      file_size    <= OFFSET_BITS'(1);
      worker_count <= NUM_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILE_SIZE:    file_size    <= cfg_data;
        REG_WORKER_COUNT: worker_count <= cfg_data[NUM_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // zero workers means one, anything above the supported count saturates
  always_comb begin
    if (worker_count == '0) begin
      workers = NUM_BITS'(1);
    end else if (worker_count > NUM_BITS'(MAX_WORKERS)) begin
      workers = NUM_BITS'(MAX_WORKERS);
    end else begin
      workers = worker_count;
    end
  end

  nars_divider #(.OFFSET_BITS(OFFSET_BITS)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_we),
    .dividend  (file_size),
    .divisor   (workers),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  nars_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .data_byte   (s_tdata),
    .end_of_file (s_tlast),
    .workers     (workers),
    .quotient    (quotient),
    .remainder   (remainder),
    .div_busy    (div_busy),
    .queue_full  (queue_full),
    .push        (push),
    .push_ctrl   (push_ctrl),
    .push_ofs    (push_ofs)
  );

  nars_fifo #(.OFFSET_BITS(OFFSET_BITS)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ctrl  (push_ctrl),
    .push_ofs   (push_ofs),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_ctrl  (head_ctrl),
    .head_ofs   (head_ofs)
  );

  nars_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ctrl  (head_ctrl),
    .head_ofs   (head_ofs),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ofs    (out_ofs),
    .out_num    (out_num),
    .out_last   (m_tlast)
  );

  // offset in the low bits, number above it, zeros to the byte
  assign m_tdata = TDATA_BITS'({out_num, out_ofs});

endmodule
